// File: rtl/core/spi3_pkg.sv
// Package: shared types and constants for the three-wire SPI register master.
package spi3_pkg;

  // Largest number of data bytes in one transaction
  localparam int unsigned MaxBytes = 8;

  // Widths
  localparam int unsigned HalfW  = 16;
  localparam int unsigned DataW  = 64;
  localparam int unsigned CountW = 4;
  localparam int unsigned BitW   = 3;
  localparam int unsigned AddrW  = 8;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  // Register map (byte address bit 2 selects the register word)
  localparam logic RegHalfPeriod = 1'b0;

  // Reset values and fixed codes
  localparam logic [HalfW-1:0] HalfPeriodReset = 16'd50;
  localparam logic [AddrW-1:0] ReadFlag        = 8'h80;
  localparam logic             CmdRead         = 1'b1;

  // Input item: one system tick
  typedef struct packed {
    logic              start_req;
    logic              cmd;
    logic [AddrW-1:0]  reg_addr;
    logic [CountW-1:0] byte_count;
    logic [DataW-1:0]  write_data;
    logic              sdio_in;
  } in_item_t;

  // Result item: pin levels and status after the tick
  typedef struct packed {
    logic             cs_n;
    logic             sclk;
    logic             sdio_out;
    logic             sdio_drive;
    logic             busy_res;
    logic             done_res;
    logic [DataW-1:0] read_data;
  } out_item_t;

endpackage

// File: rtl/core/three_wire_spi_register_master.sv
// Three-wire SPI register master (clock mode 3), one system tick per transfer.
// The result of a transfer is registered and presented in the cycle after acceptance.
// Throughput: one transfer per cycle if results drain; the output register decouples
//   the channels, so a new transfer is taken while the previous result is being taken.
// Reset (rst_n low, synchronous): idle, chip select high, clock high, half_period 50,
//   no result pending.
module three_wire_spi_register_master
  import spi3_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [PaddrW-1:0] cfg_paddr,
  input  logic [PdataW-1:0] cfg_pwdata,
  output logic [PdataW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // Configuration register
  logic [HalfW-1:0] half_period_r;

  // Transaction state
  logic              active_r, active_nxt;
  logic              reading_r, reading_nxt;
  logic              addr_phase_r, addr_phase_nxt;
  logic              high_half_r, high_half_nxt;
  logic [HalfW-1:0]  tick_r, tick_nxt;
  logic [BitW-1:0]   bit_pos_r, bit_pos_nxt;
  logic [CountW-1:0] byte_pos_r, byte_pos_nxt;
  logic [CountW-1:0] bytes_req_r, bytes_req_nxt;
  logic [AddrW-1:0]  addr_shift_r, addr_shift_nxt;
  logic [DataW-1:0]  tx_buf_r, tx_buf_nxt;
  logic [DataW-1:0]  rx_buf_r, rx_buf_nxt;

  // Result register
  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  logic in_fire;
  logic cfg_wr;

  // APB access: no wait states
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[PaddrW-1] == RegHalfPeriod);
  assign cfg_prdata = (cfg_paddr[PaddrW-1] == RegHalfPeriod)
                      ? {{(PdataW-HalfW){1'b0}}, half_period_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HalfPeriodReset;
    end else if (cfg_wr) begin
      half_period_r <= cfg_pwdata[HalfW-1:0];
    end
  end

  // Handshake: take a new tick whenever the result slot is free or draining
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state and result for one tick
  always_comb begin
    logic [HalfW:0]    tick_inc;
    logic              half_end;
    logic              done;
    logic [5:0]        rx_idx;
    logic [5:0]        tx_idx;
    logic [CountW-1:0] cnt_sat;
    logic [CountW-1:0] byte_pos_step;

    active_nxt     = active_r;
    reading_nxt    = reading_r;
    addr_phase_nxt = addr_phase_r;
    high_half_nxt  = high_half_r;
    tick_nxt       = tick_r;
    bit_pos_nxt    = bit_pos_r;
    byte_pos_nxt   = byte_pos_r;
    bytes_req_nxt  = bytes_req_r;
    addr_shift_nxt = addr_shift_r;
    tx_buf_nxt     = tx_buf_r;
    rx_buf_nxt     = rx_buf_r;
    done           = 1'b0;

    tick_inc = {1'b0, tick_r} + {{HalfW{1'b0}}, 1'b1};
    half_end = (tick_inc >= {1'b0, half_period_r});
    rx_idx   = {byte_pos_r[BitW-1:0], bit_pos_r};
    cnt_sat  = (in_data.byte_count > CountW'(MaxBytes)) ? CountW'(MaxBytes)
                                                        : in_data.byte_count;
    byte_pos_step = addr_phase_r ? '0 : (byte_pos_r + CountW'(1));

    if (active_r) begin
      if (half_end) begin
        tick_nxt = '0;
        if (!high_half_r) begin
          // end of low half: sample read data
          if (reading_r && !addr_phase_r) begin
            rx_buf_nxt[rx_idx] = in_data.sdio_in;
          end
          high_half_nxt = 1'b1;
        end else if (bit_pos_r != '0) begin
          bit_pos_nxt   = bit_pos_r - BitW'(1);
          high_half_nxt = 1'b0;
        end else begin
          // byte boundary
          bit_pos_nxt    = '1;
          addr_phase_nxt = 1'b0;
          byte_pos_nxt   = byte_pos_step;
          if (byte_pos_step >= bytes_req_r) begin
            active_nxt = 1'b0;
            done       = 1'b1;
          end else begin
            high_half_nxt = 1'b0;
          end
        end
      end else begin
        tick_nxt = tick_inc[HalfW-1:0];
      end
    end else if (in_data.start_req) begin
      // launch a transaction
      active_nxt     = 1'b1;
      reading_nxt    = (in_data.cmd == CmdRead);
      addr_phase_nxt = 1'b1;
      high_half_nxt  = 1'b0;
      tick_nxt       = '0;
      bit_pos_nxt    = '1;
      byte_pos_nxt   = '0;
      bytes_req_nxt  = cnt_sat;
      addr_shift_nxt = (in_data.cmd == CmdRead) ? (in_data.reg_addr | ReadFlag)
                                                : in_data.reg_addr;
      tx_buf_nxt     = in_data.write_data;
      rx_buf_nxt     = '0;
    end

    // Pin levels after the tick
    tx_idx = {byte_pos_nxt[BitW-1:0], bit_pos_nxt};
    out_data_nxt.sdio_drive = 1'b0;
    out_data_nxt.sdio_out   = 1'b0;
    if (active_nxt) begin
      if (addr_phase_nxt) begin
        out_data_nxt.sdio_drive = 1'b1;
        out_data_nxt.sdio_out   = addr_shift_nxt[bit_pos_nxt];
      end else if (!reading_nxt) begin
        out_data_nxt.sdio_drive = 1'b1;
        out_data_nxt.sdio_out   = tx_buf_nxt[tx_idx];
      end
    end
    out_data_nxt.cs_n      = !active_nxt;
    out_data_nxt.sclk      = !(active_nxt && !high_half_nxt);
    out_data_nxt.busy_res  = active_nxt;
    out_data_nxt.done_res  = done;
    out_data_nxt.read_data = done ? rx_buf_nxt : '0;
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      reading_r    <= 1'b0;
      addr_phase_r <= 1'b0;
      high_half_r  <= 1'b1;
      tick_r       <= '0;
      bit_pos_r    <= '1;
      byte_pos_r   <= '0;
      bytes_req_r  <= '0;
      addr_shift_r <= '0;
      tx_buf_r     <= '0;
      rx_buf_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        active_r     <= active_nxt;
        reading_r    <= reading_nxt;
        addr_phase_r <= addr_phase_nxt;
        high_half_r  <= high_half_nxt;
        tick_r       <= tick_nxt;
        bit_pos_r    <= bit_pos_nxt;
        byte_pos_r   <= byte_pos_nxt;
        bytes_req_r  <= bytes_req_nxt;
        addr_shift_r <= addr_shift_nxt;
        tx_buf_r     <= tx_buf_nxt;
        rx_buf_r     <= rx_buf_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  // Presented result mirrors the live transaction flag
  a_busy_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.busy_res == active_r) && (out_data_r.cs_n == !active_r))
    else $error("busy/cs_n disagree with transaction state");

  // Done is shown at the tick that leaves the transaction
  a_done_ends_txn: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && active_r && !active_nxt |=> out_data_r.done_res)
    else $error("transaction ended without done");

  // Read data only shown with done
  a_rdata_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.done_res |-> (out_data_r.read_data == '0))
    else $error("read_data nonzero without done");

  // Clock stays in its idle half whenever idle
  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> high_half_r || !$past(rst_n))
    else $error("clock low while idle");

  // Accepted tick always yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transfer produced no result");
`endif

endmodule
